// ===== sv/ecq_pkg.sv =====
package ecq_pkg;

  // fixed field widths of the command and result
  localparam int ID_W       = 5;
  localparam int FUNC_W     = 2;
  localparam int LAYER_W    = 3;
  localparam int IN_COORD_W = 24;
  localparam int IN_SIZE_W  = 23;
  localparam int MATRIX_W   = 64;

  // default configuration
  localparam int MAX_ENTITIES_DEF = 32;
  localparam int NUM_LAYERS_DEF   = 8;
  localparam int COORD_BITS_DEF   = 24;

  // command function codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // shape kinds
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_REMOVE,
    OP_QUERY
  } op_e;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic [ID_W-1:0]              entity_id;
    logic                         shape_kind;
    logic [LAYER_W-1:0]           layer;
    logic signed [IN_COORD_W-1:0] pos_x;
    logic signed [IN_COORD_W-1:0] pos_y;
    logic [IN_SIZE_W-1:0]         width;
    logic [IN_SIZE_W-1:0]         height;
    logic [IN_SIZE_W-1:0]         radius;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] hit_id;
    logic            hit_valid;
    logic            last;
  } res_t;

endpackage

// ===== sv/ecq_ram.sv =====
module ecq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/ecq_front.sv =====
module ecq_front
  import ecq_pkg::*;
#(
  parameter int MAX_ENTITIES = MAX_ENTITIES_DEF,
  parameter int NUM_LAYERS   = NUM_LAYERS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int SW    = $clog2(MAX_ENTITIES),
  localparam int CW    = COORD_BITS,
  localparam int SZW   = COORD_BITS - 1,
  localparam int REC_W = 1 + LAYER_W + 2 * CW + 3 * SZW,
  localparam int ENT_W = 2 + SW + REC_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  req_t             req_i,
  output logic             busy_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [ENT_W-1:0] head_o
);

  localparam logic signed [31:0] C_HI = (32'sd1 <<< (COORD_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] C_LO = -C_HI - 32'sd1;

  function automatic logic [CW-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [31:0] t;
    if (v > C_HI) t = C_HI;
    else if (v < C_LO) t = C_LO;
    else t = v;
    return t[CW-1:0];
  endfunction

  function automatic logic [SZW-1:0] sat_size(input logic signed [31:0] v);
    logic signed [31:0] t;
    if (v > C_HI) t = C_HI;
    else t = v;
    return t[SZW-1:0];
  endfunction

  logic             accept;
  logic             in_range;
  logic [LAYER_W-1:0] layer_sat;
  op_e              op;
  logic [SW-1:0]    slot;
  logic [REC_W-1:0] rec;
  logic [ENT_W-1:0] entry;

  logic [ENT_W-1:0] q_mem [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign busy_o = (cnt_q == 2'd2);
  assign accept = start_i && !busy_o;

  // classify the request and saturate its fields
  always_comb begin
    in_range = (32'(req_i.entity_id) < MAX_ENTITIES);
    slot     = SW'(req_i.entity_id);
    if (32'(req_i.layer) >= NUM_LAYERS) layer_sat = LAYER_W'(NUM_LAYERS - 1);
    else layer_sat = req_i.layer;
    op = OP_NOP;
    if (in_range) begin
      unique case (req_i.func)
        FUNC_INSERT: op = OP_INSERT;
        FUNC_REMOVE: op = OP_REMOVE;
        FUNC_QUERY:  op = OP_QUERY;
        default:     op = OP_NOP;
      endcase
    end
    rec = {req_i.shape_kind, layer_sat,
           sat_coord(32'(req_i.pos_x)), sat_coord(32'(req_i.pos_y)),
           sat_size(32'(req_i.width)), sat_size(32'(req_i.height)),
           sat_size(32'(req_i.radius))};
    entry = {op, slot, rec};
  end

  // two-entry request queue
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept) wr_ptr_d = !wr_ptr_q;
    if (pop_i) rd_ptr_d = !rd_ptr_q;
    if (accept && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (!accept && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= entry;
    end
  end

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_mem[rd_ptr_q];

endmodule

// ===== sv/ecq_back.sv =====
module ecq_back
  import ecq_pkg::*;
#(
  parameter int MAX_ENTITIES = MAX_ENTITIES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int SW    = $clog2(MAX_ENTITIES),
  localparam int IW    = $clog2(MAX_ENTITIES + 1),
  localparam int CW    = COORD_BITS,
  localparam int SZW   = COORD_BITS - 1,
  localparam int REC_W = 1 + LAYER_W + 2 * CW + 3 * SZW,
  localparam int ENT_W = 2 + SW + REC_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [MATRIX_W-1:0] layer_matrix_i,
  input  logic                head_valid_i,
  input  logic [ENT_W-1:0]    head_i,
  output logic                pop_o,
  output logic                ram_we_o,
  output logic [SW-1:0]       ram_waddr_o,
  output logic [REC_W-1:0]    ram_wdata_o,
  output logic [SW-1:0]       ram_raddr_o,
  input  logic [REC_W-1:0]    ram_rdata_i,
  output logic                res_strobe_o,
  output res_t                res_o
);

  // record layout
  localparam int R_OFF  = 0;
  localparam int H_OFF  = SZW;
  localparam int W_OFF  = 2 * SZW;
  localparam int PY_OFF = 3 * SZW;
  localparam int PX_OFF = 3 * SZW + CW;
  localparam int LY_OFF = 3 * SZW + 2 * CW;
  localparam int K_OFF  = LY_OFF + LAYER_W;
  localparam int EW     = CW + 2;
  localparam int MW     = CW + 1;
  localparam int SQW    = 2 * MW;
  localparam int RSQW   = 2 * CW;
  localparam logic [IW-1:0] SCAN_END = IW'(MAX_ENTITIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QLOAD,
    ST_SCAN
  } state_e;

  state_e            state_q;
  logic [MAX_ENTITIES-1:0] valid_q;
  logic [SW-1:0]     qslot_q;
  logic [IW-1:0]     iss_q;
  logic              s0_q, s1_q, s2_q;
  logic [SW-1:0]     s0_id_q, s1_id_q, s2_id_q;
  logic              held_v_q;
  logic [SW-1:0]     held_id_q;
  logic              res_strobe_q;
  res_t              res_q;
  logic [REC_W-1:0]  qrec_q;

  // stage registers of the pair test
  logic              s1_bb_q, s1_bbhit_q;
  logic [MW-1:0]     dxm_q, dym_q;
  logic [CW-1:0]     rs_q;
  logic              s2_bb_q, s2_bbhit_q;
  logic [SQW-1:0]    dx2_q, dy2_q;
  logic [RSQW-1:0]   r2_q;

  op_e               e_op;
  logic [SW-1:0]     e_slot;
  logic [REC_W-1:0]  e_rec;
  logic              issue, finish, cand, hit3;

  assign e_op  = op_e'(head_i[ENT_W-1 -: 2]);
  assign e_slot = head_i[REC_W +: SW];
  assign e_rec = head_i[REC_W-1:0];

  assign pop_o       = (state_q == ST_IDLE) && head_valid_i;
  assign ram_we_o    = pop_o && (e_op == OP_INSERT);
  assign ram_waddr_o = e_slot;
  assign ram_wdata_o = e_rec;
  assign ram_raddr_o = (state_q == ST_IDLE) ? e_slot : iss_q[SW-1:0];

  assign issue  = ((state_q == ST_QLOAD) || (state_q == ST_SCAN)) && (iss_q < SCAN_END);
  assign finish = (state_q == ST_SCAN) && !(iss_q < SCAN_END) && !s0_q && !s1_q && !s2_q;

  // unpacked query and scanned entity
  logic                     a_kind, b_kind;
  logic [LAYER_W-1:0]       a_ly, b_ly;
  logic signed [EW-1:0]     ax, ay, aw, ah, bx, by, bw, bh;
  logic [SZW-1:0]           ar, br;
  logic signed [EW-1:0]     aex, aey, bex, bey;
  logic signed [EW-1:0]     px, py, pex, pey, cx, cy, clx, cly, mnx, mny;
  logic signed [EW-1:0]     dx, dy;
  logic                     mixed, a_is_box, bb, bbhit;
  logic [CW-1:0]            rs;
  logic [5:0]               lbit;

  // first stage: distances, overlap and layer filter
  always_comb begin
    a_kind = qrec_q[K_OFF];
    b_kind = ram_rdata_i[K_OFF];
    a_ly   = qrec_q[LY_OFF +: LAYER_W];
    b_ly   = ram_rdata_i[LY_OFF +: LAYER_W];
    ax = EW'(signed'(qrec_q[PX_OFF +: CW]));
    ay = EW'(signed'(qrec_q[PY_OFF +: CW]));
    aw = EW'(qrec_q[W_OFF +: SZW]);
    ah = EW'(qrec_q[H_OFF +: SZW]);
    ar = qrec_q[R_OFF +: SZW];
    bx = EW'(signed'(ram_rdata_i[PX_OFF +: CW]));
    by = EW'(signed'(ram_rdata_i[PY_OFF +: CW]));
    bw = EW'(ram_rdata_i[W_OFF +: SZW]);
    bh = EW'(ram_rdata_i[H_OFF +: SZW]);
    br = ram_rdata_i[R_OFF +: SZW];

    aex = ax + aw;
    aey = ay + ah;
    bex = bx + bw;
    bey = by + bh;
    bb    = (a_kind == KIND_BOX) && (b_kind == KIND_BOX);
    bbhit = (aex >= bx) && (bex >= ax) && (aey >= by) && (bey >= ay);

    // box against circle: nearest box point
    mixed    = (a_kind != b_kind);
    a_is_box = (a_kind == KIND_BOX);
    px  = a_is_box ? ax : bx;
    py  = a_is_box ? ay : by;
    pex = a_is_box ? aex : bex;
    pey = a_is_box ? aey : bey;
    cx  = a_is_box ? bx : ax;
    cy  = a_is_box ? by : ay;
    mnx = (cx < pex) ? cx : pex;
    mny = (cy < pey) ? cy : pey;
    clx = (px > mnx) ? px : mnx;
    cly = (py > mny) ? py : mny;

    if (mixed) begin
      dx = cx - clx;
      dy = cy - cly;
      rs = a_is_box ? CW'(br) : CW'(ar);
    end else begin
      dx = bx - ax;
      dy = by - ay;
      rs = CW'(ar) + CW'(br);
    end

    lbit = {a_ly, b_ly};
    cand = s0_q && valid_q[s0_id_q] && (s0_id_q != qslot_q) && layer_matrix_i[lbit];
  end

  // last stage: squared distance against squared radius
  logic [SQW:0] dsum;
  always_comb begin
    dsum = {1'b0, dx2_q} + {1'b0, dy2_q};
    hit3 = s2_q && (s2_bb_q ? s2_bbhit_q : (dsum <= (SQW + 1)'(r2_q)));
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_QLOAD) begin
      qrec_q <= ram_rdata_i;
    end
    s1_bb_q    <= bb;
    s1_bbhit_q <= bbhit;
    dxm_q      <= dx[EW-1] ? MW'(-dx) : MW'(dx);
    dym_q      <= dy[EW-1] ? MW'(-dy) : MW'(dy);
    rs_q       <= rs;
    s2_bb_q    <= s1_bb_q;
    s2_bbhit_q <= s1_bbhit_q;
    dx2_q      <= SQW'(dxm_q) * SQW'(dxm_q);
    dy2_q      <= SQW'(dym_q) * SQW'(dym_q);
    r2_q       <= RSQW'(rs_q) * RSQW'(rs_q);
  end

  // sequencer, slot valid bits and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      qslot_q      <= '0;
      iss_q        <= '0;
      s0_q         <= 1'b0;
      s1_q         <= 1'b0;
      s2_q         <= 1'b0;
      s0_id_q      <= '0;
      s1_id_q      <= '0;
      s2_id_q      <= '0;
      held_v_q     <= 1'b0;
      held_id_q    <= '0;
      res_strobe_q <= 1'b0;
      res_q        <= '0;
    end else begin
      res_strobe_q <= 1'b0;
      s0_q    <= issue;
      s0_id_q <= iss_q[SW-1:0];
      s1_q    <= cand;
      s1_id_q <= s0_id_q;
      s2_q    <= s1_q;
      s2_id_q <= s1_id_q;
      if (issue) iss_q <= iss_q + IW'(1);

      // a new hit releases the one held before it
      if (hit3) begin
        if (held_v_q) begin
          res_strobe_q    <= 1'b1;
          res_q.hit_id    <= ID_W'(held_id_q);
          res_q.hit_valid <= 1'b1;
          res_q.last      <= 1'b0;
        end
        held_v_q  <= 1'b1;
        held_id_q <= s2_id_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            if (e_op == OP_QUERY && valid_q[e_slot]) begin
              qslot_q <= e_slot;
              iss_q   <= '0;
              state_q <= ST_QLOAD;
            end else begin
              if (e_op == OP_INSERT) valid_q[e_slot] <= 1'b1;
              if (e_op == OP_REMOVE) valid_q[e_slot] <= 1'b0;
              res_strobe_q    <= 1'b1;
              res_q.hit_id    <= '0;
              res_q.hit_valid <= 1'b0;
              res_q.last      <= 1'b1;
            end
          end
        end
        ST_QLOAD: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (finish) begin
            res_strobe_q    <= 1'b1;
            res_q.hit_id    <= held_v_q ? ID_W'(held_id_q) : '0;
            res_q.hit_valid <= held_v_q;
            res_q.last      <= 1'b1;
            held_v_q        <= 1'b0;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// ===== sv/entity_collision_query.sv =====
// Entity collision query. Commands (insert, remove, query) are taken while busy is low
// into a two-entry queue; busy rises only when both entries are waiting. Insert, remove
// and any other command give one empty result. A query of a valid slot reads every slot
// once from the entity memory, one read per cycle, and the back end takes no further
// command from the queue until the last result of that query is driven; the single
// memory read port sets the rate. Hits come in ascending slot order, one per cycle at
// most, each shown for one cycle on res_strobe_o; the receiver cannot stall, so it
// must take every strobe. The last result of each command carries last = 1.
module entity_collision_query
  import ecq_pkg::*;
#(
  parameter int MAX_ENTITIES = MAX_ENTITIES_DEF,
  parameter int NUM_LAYERS   = NUM_LAYERS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  req_t                req_i,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [MATRIX_W-1:0] cfg_wdata_i,
  output logic                res_strobe_o,
  output res_t                res_o
);

  localparam int SW    = $clog2(MAX_ENTITIES);
  localparam int REC_W = 1 + LAYER_W + 2 * COORD_BITS + 3 * (COORD_BITS - 1);
  localparam int ENT_W = 2 + SW + REC_W;

  logic [MATRIX_W-1:0] layer_matrix_q;
  logic                head_valid, pop;
  logic [ENT_W-1:0]    head;
  logic                ram_we;
  logic [SW-1:0]       ram_waddr, ram_raddr;
  logic [REC_W-1:0]    ram_wdata, ram_rdata;

  // layer matrix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_matrix_q <= '1;
    end else if (cfg_we_i) begin
      layer_matrix_q <= cfg_wdata_i;
    end
  end

  ecq_front #(
    .MAX_ENTITIES(MAX_ENTITIES),
    .NUM_LAYERS  (NUM_LAYERS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  ecq_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_ENTITIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ecq_back #(
    .MAX_ENTITIES(MAX_ENTITIES),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .layer_matrix_i(layer_matrix_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .res_strobe_o  (res_strobe_o),
    .res_o         (res_o)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ecq_pkg::*;

  // function code with no command behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // entity table kept by the predictor
  typedef struct {
    bit           valid;
    bit           kind;
    int unsigned  layer;
    longint       px;
    longint       py;
    longint       w;
    longint       h;
    longint       r;
  } slot_t;

  // collision predictor and pending-result store
  class collision_scoreboard;
    slot_t        slots[32];
    logic [63:0]  matrix;
    res_t         pending[$];
    int           errors;

    function new();
      matrix = '1;
      errors = 0;
      foreach (slots[i]) slots[i].valid = 0;
    endfunction

    function longint unsigned sqr(longint d);
      longint unsigned m;
      m = d < 0 ? -d : d;
      return m * m;
    endfunction

    function longint lmax(longint a, longint b);
      return a > b ? a : b;
    endfunction

    function longint lmin(longint a, longint b);
      return a < b ? a : b;
    endfunction

    function bit box_circle(int b, int c);
      longint cx, cy;
      cx = lmax(slots[b].px, lmin(slots[c].px, slots[b].px + slots[b].w));
      cy = lmax(slots[b].py, lmin(slots[c].py, slots[b].py + slots[b].h));
      return sqr(slots[c].px - cx) + sqr(slots[c].py - cy) <= sqr(slots[c].r);
    endfunction

    function bit overlaps(int a, int b);
      if (slots[a].kind == KIND_BOX && slots[b].kind == KIND_BOX)
        return slots[a].px + slots[a].w >= slots[b].px &&
               slots[b].px + slots[b].w >= slots[a].px &&
               slots[a].py + slots[a].h >= slots[b].py &&
               slots[b].py + slots[b].h >= slots[a].py;
      if (slots[a].kind == KIND_CIRCLE && slots[b].kind == KIND_CIRCLE)
        return sqr(slots[b].px - slots[a].px) + sqr(slots[b].py - slots[a].py)
               <= sqr(slots[a].r + slots[b].r);
      return slots[a].kind == KIND_BOX ? box_circle(a, b) : box_circle(b, a);
    endfunction

    // note an accepted request
    function void note_request(req_t q);
      int   s;
      int   n;
      res_t e;
      s = 32'(q.entity_id);
      n = 0;
      if (q.func == FUNC_INSERT) begin
        slots[s].valid = 1;
        slots[s].kind = q.shape_kind;
        slots[s].layer = 32'(q.layer);
        slots[s].px = longint'(q.pos_x);
        slots[s].py = longint'(q.pos_y);
        slots[s].w = longint'({1'b0, q.width});
        slots[s].h = longint'({1'b0, q.height});
        slots[s].r = longint'({1'b0, q.radius});
      end else if (q.func == FUNC_REMOVE) begin
        slots[s].valid = 0;
      end else if (q.func == FUNC_QUERY && slots[s].valid) begin
        for (int o = 0; o < 32; o++) begin
          if (o == s || !slots[o].valid) continue;
          if (!matrix[slots[s].layer * 8 + slots[o].layer]) continue;
          if (overlaps(s, o)) begin
            e.hit_id = o[4:0];
            e.hit_valid = 1;
            e.last = 0;
            pending = {pending, e};
            n++;
          end
        end
      end
      if (n == 0) begin
        e = '0;
        e.last = 1;
        pending = {pending, e};
      end else begin
        pending[pending.size() - 1].last = 1;
      end
    endfunction

    // check one result against the oldest expectation
    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result hit_id=%0d hit_valid=%0b last=%0b",
                 $time, got.hit_id, got.hit_valid, got.last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit_id !== e.hit_id)
        $display("%0t hit_id expected %0d actual %0d", $time, e.hit_id, got.hit_id);
      if (got.hit_valid !== e.hit_valid)
        $display("%0t hit_valid expected %0b actual %0b", $time, e.hit_valid,
                 got.hit_valid);
      if (got.last !== e.last)
        $display("%0t last expected %0b actual %0b", $time, e.last, got.last);
      if (got !== e) errors++;
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                start = 0;
  req_t                req_i = '0;
  logic                busy;
  logic                cfg_we_i = 0;
  logic [MATRIX_W-1:0] cfg_wdata_i = '0;
  logic                res_strobe_o;
  res_t                res_o;

  collision_scoreboard sb = new();
  int                  idle_cycles = 0;
  bit                  timed_out = 0;
  localparam int       WATCHDOG = 5000;

  entity_collision_query dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .res_strobe_o(res_strobe_o), .res_o(res_o)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe_o) sb.check_result(res_o);
      if (res_strobe_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) timed_out <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (timed_out) begin
      $display("[entity_collision_query] ERROR");
      $finish;
    end
  end

  // send one request and wait until it is taken
  task automatic send_request(req_t q);
    start <= 1;
    req_i <= q;
    do @(posedge clk_i); while (busy);
    sb.note_request(q);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  // write the layer matrix with the block idle
  task automatic write_matrix(logic [63:0] v);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.matrix = v;
  endtask

  function automatic req_t make_entity(int id, bit kind, int ly, int x, int y,
                                       int w, int h, int r);
    req_t q;
    q = '0;
    q.func = FUNC_INSERT;
    q.entity_id = ID_W'(id);
    q.shape_kind = kind;
    q.layer = LAYER_W'(ly);
    q.pos_x = IN_COORD_W'(x);
    q.pos_y = IN_COORD_W'(y);
    q.width = IN_SIZE_W'(w);
    q.height = IN_SIZE_W'(h);
    q.radius = IN_SIZE_W'(r);
    return q;
  endfunction

  function automatic req_t make_cmd(logic [1:0] f, int id);
    req_t q;
    q = '0;
    q.func = f;
    q.entity_id = ID_W'(id);
    return q;
  endfunction

  // random request clustered in a small world so hits happen
  function automatic req_t random_request();
    req_t q;
    int   sel;
    q.func = FUNC_QUERY;
    q.entity_id = ID_W'($urandom_range(0, 31));
    q.shape_kind = 1'($urandom_range(0, 1));
    q.layer = LAYER_W'($urandom_range(0, 7));
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      q.pos_x = IN_COORD_W'($urandom);
      q.pos_y = IN_COORD_W'($urandom);
      q.width = IN_SIZE_W'($urandom);
      q.height = IN_SIZE_W'($urandom);
      q.radius = IN_SIZE_W'($urandom);
    end else begin
      q.pos_x = IN_COORD_W'($signed($urandom_range(0, 8192)) - 4096);
      q.pos_y = IN_COORD_W'($signed($urandom_range(0, 8192)) - 4096);
      q.width = IN_SIZE_W'($urandom_range(0, 2048));
      q.height = IN_SIZE_W'($urandom_range(0, 2048));
      q.radius = IN_SIZE_W'($urandom_range(0, 1536));
    end
    sel = $urandom_range(0, 19);
    if (sel < 9) q.func = FUNC_INSERT;
    else if (sel < 12) q.func = FUNC_REMOVE;
    else if (sel < 19) q.func = FUNC_QUERY;
    else q.func = FUNC_UNUSED;
    return q;
  endfunction

  task automatic random_phase(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(random_request());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 40));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, each shape pairing, every command
    send_request(make_cmd(FUNC_QUERY, 0));
    send_request(make_cmd(FUNC_REMOVE, 5));
    send_request(make_entity(0, KIND_BOX, 0, 0, 0, 256, 256, 0));
    send_request(make_entity(1, KIND_BOX, 0, 256, 256, 10, 10, 0));
    send_request(make_entity(2, KIND_CIRCLE, 1, 300, 0, 0, 0, 44));
    send_request(make_entity(3, KIND_CIRCLE, 2, 600, 0, 0, 0, 256));
    send_request(make_entity(31, KIND_BOX, 7, -8388608, -8388608,
                             8388607, 8388607, 8388607));
    send_request(make_entity(30, KIND_CIRCLE, 7, 8388607, 8388607, 8388607, 8388607,
                             8388607));
    send_request(make_cmd(FUNC_QUERY, 0));
    send_request(make_cmd(FUNC_QUERY, 2));
    send_request(make_cmd(FUNC_QUERY, 30));
    send_request(make_cmd(FUNC_QUERY, 31));
    send_request(make_cmd(FUNC_UNUSED, 1));
    send_request(make_entity(1, KIND_CIRCLE, 3, 0, 0, 0, 0, 0));
    send_request(make_cmd(FUNC_QUERY, 1));
    send_request(make_cmd(FUNC_REMOVE, 2));
    send_request(make_cmd(FUNC_REMOVE, 2));
    send_request(make_cmd(FUNC_QUERY, 2));
    send_request(make_cmd(FUNC_QUERY, 3));

    write_matrix('0);
    send_request(make_cmd(FUNC_QUERY, 0));
    random_phase(60);
    write_matrix({$urandom, $urandom});
    random_phase(100);
    write_matrix(64'h8142_2418_1824_4281);
    random_phase(60);
    write_matrix('1);
    random_phase(120);

    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[entity_collision_query] OK");
    else
      $display("[entity_collision_query] ERROR");
    $finish;
  end
endmodule

// ===== entity_collision_query.f =====
sv/ecq_pkg.sv
sv/ecq_ram.sv
sv/ecq_front.sv
sv/ecq_back.sv
sv/entity_collision_query.sv
verif/tb_top.sv
